// ===== rtl/pfms_pkg.sv =====
// Shared constants, types and codes for the pose fit map score block.
// Used by pfms_xform, pfms_div and pose_fit_map_score; depends on nothing else.
package pfms_pkg;

  localparam int MAX_POINTS   = 512;
  localparam int FLOOR_WIDTH  = 1024;
  localparam int FLOOR_HEIGHT = 1024;

  localparam int FLOOR_DEPTH = FLOOR_WIDTH * FLOOR_HEIGHT;
  localparam int PT_AW = $clog2(MAX_POINTS);
  localparam int PC_W  = $clog2(MAX_POINTS + 1);
  localparam int FA_W  = $clog2(FLOOR_DEPTH);
  localparam int COL_W = $clog2(FLOOR_WIDTH);
  localparam int ROW_W = $clog2(FLOOR_HEIGHT);

  localparam int DIM_W   = 11;
  localparam int PPM_W   = 16;
  localparam int CNT_W   = 10;
  localparam int COORD_W = 16;
  localparam int PIX_W   = 8;

  localparam int SUM_W  = $clog2(255 * MAX_POINTS + 1);
  localparam int DEN_W  = SUM_W;
  localparam int QUO_W  = 17;
  localparam int NUM_W  = DEN_W + QUO_W;
  localparam int PROD_W = 34 + PPM_W + 1;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 2;

  localparam logic [QUO_W-1:0] COST_ONE = QUO_W'(65536);

  localparam logic [PPM_W-1:0] PPM_RESET  = PPM_W'(25600);
  localparam logic [DIM_W-1:0] COLS_RESET = DIM_W'(1024);
  localparam logic [DIM_W-1:0] ROWS_RESET = DIM_W'(1024);
  localparam logic [CNT_W-1:0] PCNT_RESET = '0;

  localparam logic [CFG_IDX_W-1:0] CFG_PPM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PCNT = 2'd3;

  typedef enum logic [1:0] {
    CMD_FLOOR = 2'd0,
    CMD_POINT = 2'd1,
    CMD_EVAL  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cos_angle;
    logic signed [COORD_W-1:0] sin_angle;
    logic signed [COORD_W-1:0] shift_x;
    logic signed [COORD_W-1:0] shift_y;
  } pose_t;

  typedef struct packed {
    logic [PPM_W-1:0] ppm;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
  } xform_cfg_t;

  typedef struct packed {
    logic            valid;
    logic            hit;
    logic [FA_W-1:0] addr;
  } pix_t;

endpackage

// ===== rtl/pfms_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for both the floor image and the line point list; no dependencies.
module pfms_ram #(
  parameter int DEPTH = 512,
  parameter int DW = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pfms_xform.sv =====
// Four-stage pose transform: rotate, translate, scale and bound-check one point.
// Depends on pfms_pkg for the pose, configuration and pixel types.
module pfms_xform
  import pfms_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  pose_t                     pose,
  input  xform_cfg_t                cfg,
  output pix_t                      pix
);

  localparam int HI_W = PROD_W - 32;

  logic [2:0] vld;
  logic signed [31:0] p_cx, p_sy, p_sx, p_cy;
  logic signed [33:0] xr, yr;
  logic signed [PROD_W-1:0] vx, vy;
  logic signed [PPM_W:0] ppm_s;
  logic x_ok, y_ok;
  logic [HI_W-1:0] x_hi, y_hi;
  logic [COL_W-1:0] px;
  logic [ROW_W-1:0] py;

  function automatic logic coord_ok(logic signed [PROD_W-1:0] v, logic [DIM_W-1:0] lim);
    logic [HI_W-1:0] hi;
    logic neg_small;
    hi = v[PROD_W-1:32];
    neg_small = (&hi) && (v[31:0] != '0);
    coord_ok = (!v[PROD_W-1] && (hi < HI_W'(lim))) || (neg_small && (lim != '0));
  endfunction

  function automatic logic [HI_W-1:0] coord_idx(logic signed [PROD_W-1:0] v);
    coord_idx = v[PROD_W-1] ? '0 : v[PROD_W-1:32];
  endfunction

  assign ppm_s = $signed({1'b0, cfg.ppm});

  always_comb begin
    x_ok = coord_ok(vx, cfg.cols);
    y_ok = coord_ok(vy, cfg.rows);
    x_hi = coord_idx(vx);
    y_hi = coord_idx(vy);
    px = x_hi[COL_W-1:0];
    py = y_hi[ROW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      pix.valid <= 1'b0;
    end else begin
      vld <= {vld[1:0], in_valid};
      pix.valid <= vld[2];
    end
    p_cx <= pose.cos_angle * point_x;
    p_sy <= pose.sin_angle * point_y;
    p_sx <= pose.sin_angle * point_x;
    p_cy <= pose.cos_angle * point_y;
    xr <= 34'(p_cx) + 34'(p_sy) + (34'(pose.shift_x) <<< 14);
    yr <= 34'(p_cy) - 34'(p_sx) + (34'(pose.shift_y) <<< 14);
    vx <= xr * ppm_s;
    vy <= yr * ppm_s;
    pix.hit <= x_ok && y_ok;
    pix.addr <= FA_W'(py) * FA_W'(FLOOR_WIDTH) + FA_W'(px);
  end

endmodule

// ===== rtl/pfms_div.sv =====
// Restoring divider, one quotient bit per cycle, for the final cost.
// Depends on pfms_pkg for the numerator, denominator and quotient widths.
module pfms_div
  import pfms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quot
);

  localparam int STEP_W = $clog2(QUO_W + 1);

  logic busy;
  logic [STEP_W-1:0] steps;
  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] low;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0] shifted;
  logic take;

  assign shifted = {rem, low[QUO_W-1]};
  assign take = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= STEP_W'(QUO_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[NUM_W-1:QUO_W];
      low <= num[QUO_W-1:0];
      den_r <= den;
      quot <= '0;
    end else if (busy) begin
      rem <= take ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
      low <= {low[QUO_W-2:0], 1'b0};
      quot <= {quot[QUO_W-2:0], take};
    end
  end

endmodule

// ===== rtl/pose_fit_map_score.sv =====
// Top level of the pose fit map score block: stores, command sequencer, output.
// Depends on pfms_pkg, pfms_ram, pfms_xform and pfms_div.
//
// Write requests fill one floor pixel or one line point each.
// An evaluate request streams the stored points out of the point memory at one per
// cycle through a four-stage transform into the floor memory, then runs a 17-step
// serial divider for the cost. With a point count of zero it goes straight to the
// finish state and gives the result without reading either memory.
// Requests are taken one at a time while an unread result waits in the output
// register. Neither memory is cleared by reset.
module pose_fit_map_score
  import pfms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // floor_address, floor_value, point_slot, point_x, point_y,
  // cos_angle, sin_angle, shift_x, shift_y, zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // cmd
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // byte_sum, hit_count, cost, zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  // no_points
  output logic [0:0]            m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]           cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_DIVIDE, S_WAIT, S_FINISH} state_t;

  state_t state;
  cmd_t cmd;
  logic s_acc;

  logic [19:0] floor_address;
  logic [PIX_W-1:0] floor_value;
  logic [8:0] point_slot;
  logic signed [COORD_W-1:0] point_x, point_y;
  pose_t pose_in, pose;

  logic [PPM_W-1:0] pixels_per_metre;
  logic [DIM_W-1:0] floor_columns, floor_rows;
  logic [CNT_W-1:0] point_count;
  logic [DIM_W-1:0] cols_lim, rows_lim;
  logic [PC_W-1:0] n_lim, n_run;
  xform_cfg_t xcfg;

  logic [PC_W-1:0] issue_cnt, acc_cnt;
  logic pt_re, pt_vld;
  logic [2*COORD_W-1:0] pt_rdata;
  pix_t pix;
  logic acc_vld, acc_hit;
  logic [PIX_W-1:0] floor_rdata;
  logic [SUM_W-1:0] sum;
  logic [PC_W-1:0] hits;
  logic [DEN_W-1:0] den;
  logic [QUO_W-1:0] cost;

  logic floor_we, point_we;
  logic div_start, div_done;
  logic [NUM_W-1:0] div_num;
  logic [QUO_W-1:0] div_quot;

  assign cmd = cmd_t'(s_tuser);
  assign floor_address = s_tdata[19:0];
  assign floor_value = s_tdata[27:20];
  assign point_slot = s_tdata[36:28];
  assign point_x = s_tdata[52:37];
  assign point_y = s_tdata[68:53];
  assign pose_in.cos_angle = s_tdata[84:69];
  assign pose_in.sin_angle = s_tdata[100:85];
  assign pose_in.shift_x = s_tdata[116:101];
  assign pose_in.shift_y = s_tdata[132:117];

  assign s_tready = (state == S_IDLE);
  assign s_acc = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign cols_lim = (32'(floor_columns) > FLOOR_WIDTH) ? DIM_W'(FLOOR_WIDTH) : floor_columns;
  assign rows_lim = (32'(floor_rows) > FLOOR_HEIGHT) ? DIM_W'(FLOOR_HEIGHT) : floor_rows;
  assign n_lim = (32'(point_count) > MAX_POINTS) ? PC_W'(MAX_POINTS) : PC_W'(point_count);

  assign xcfg.ppm = pixels_per_metre;
  assign xcfg.cols = cols_lim;
  assign xcfg.rows = rows_lim;

  always_comb begin
    floor_we = 1'b0;
    point_we = 1'b0;
    if (s_acc) begin
      unique case (cmd)
        CMD_FLOOR: floor_we = 32'(floor_address) < FLOOR_DEPTH;
        CMD_POINT: point_we = 32'(point_slot) < MAX_POINTS;
        CMD_EVAL: ;
        default: ;
      endcase
    end
  end

  assign pt_re = (state == S_RUN) && (issue_cnt < n_run);
  assign div_start = (state == S_DIVIDE);
  assign div_num = (NUM_W'(den - sum) << 16) + NUM_W'(den >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_per_metre <= PPM_RESET;
      floor_columns <= COLS_RESET;
      floor_rows <= ROWS_RESET;
      point_count <= PCNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PPM: pixels_per_metre <= cfg_data;
        CFG_COLS: floor_columns <= cfg_data[DIM_W-1:0];
        CFG_ROWS: floor_rows <= cfg_data[DIM_W-1:0];
        CFG_PCNT: point_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  pfms_ram #(.DEPTH(MAX_POINTS), .DW(2 * COORD_W)) u_point_ram (
    .clk(clk),
    .we(point_we),
    .waddr(PT_AW'(point_slot)),
    .wdata({point_y, point_x}),
    .re(pt_re),
    .raddr(issue_cnt[PT_AW-1:0]),
    .rdata(pt_rdata)
  );

  pfms_xform u_xform (
    .clk(clk),
    .rst(rst),
    .in_valid(pt_vld),
    .point_x(pt_rdata[COORD_W-1:0]),
    .point_y(pt_rdata[2*COORD_W-1:COORD_W]),
    .pose(pose),
    .cfg(xcfg),
    .pix(pix)
  );

  pfms_ram #(.DEPTH(FLOOR_DEPTH), .DW(PIX_W)) u_floor_ram (
    .clk(clk),
    .we(floor_we),
    .waddr(FA_W'(floor_address)),
    .wdata(floor_value),
    .re(pix.valid),
    .raddr(pix.addr),
    .rdata(floor_rdata)
  );

  pfms_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num(div_num),
    .den(den),
    .done(div_done),
    .quot(div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      pt_vld <= 1'b0;
      acc_vld <= 1'b0;
      issue_cnt <= '0;
      acc_cnt <= '0;
      n_run <= '0;
      sum <= '0;
      hits <= '0;
    end else begin
      pt_vld <= pt_re;
      acc_vld <= pix.valid;
      acc_hit <= pix.hit;
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_acc && cmd == CMD_EVAL) begin
            pose <= pose_in;
            n_run <= n_lim;
            issue_cnt <= '0;
            acc_cnt <= '0;
            sum <= '0;
            hits <= '0;
            den <= DEN_W'(32'(n_lim) * 255);
            cost <= COST_ONE;
            state <= (n_lim == '0) ? S_FINISH : S_RUN;
          end
        end
        S_RUN: begin
          if (pt_re) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (acc_vld) begin
            acc_cnt <= acc_cnt + 1'b1;
            if (acc_hit) begin
              sum <= sum + SUM_W'(floor_rdata);
              hits <= hits + 1'b1;
            end
            if (acc_cnt == n_run - 1'b1) begin
              state <= S_DIVIDE;
            end
          end
        end
        S_DIVIDE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            cost <= div_quot;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {4'b0, cost, CNT_W'(hits), 17'(sum)};
            m_tuser <= (n_run == '0);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_hits_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (hits <= n_run))
    else $error("hit count exceeds the points in use");

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_WAIT))
    else $error("divider finished outside the wait state");

  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (div_quot <= COST_ONE))
    else $error("cost quotient above one");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FINISH))
    else $error("result raised outside the finish state");

endmodule
